>>> design/symmetric_matrix_inverse_3x3_core_defines.svh
// assertion helpers for the core design file
`ifndef SYMMETRIC_MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define SYMMETRIC_MATRIX_INVERSE_3X3_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SMI3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// next-cycle implication, checked out of reset
`define SMI3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) else $error(msg);

`endif

>>> design/smi3_pkg.sv
`timescale 1ns / 1ps
package smi3_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned EW = 32;  // entry width
  localparam int unsigned CW = 65;  // cofactor width, signed
  localparam int unsigned DW = 99;  // determinant width, signed
  localparam int unsigned QB = 33;  // quotient bits kept
  localparam int unsigned RW = DW + QB + 1;  // remainder width
  localparam int unsigned NL = 6;   // lanes, one per inverse entry

  typedef struct packed {
    logic signed [EW-1:0] m_xx;
    logic signed [EW-1:0] m_xy;
    logic signed [EW-1:0] m_xz;
    logic signed [EW-1:0] m_yy;
    logic signed [EW-1:0] m_yz;
    logic signed [EW-1:0] m_zz;
  } in_word_t;

  typedef struct packed {
    logic signed [EW-1:0] inv_xx;
    logic signed [EW-1:0] inv_xy;
    logic signed [EW-1:0] inv_xz;
    logic signed [EW-1:0] inv_yy;
    logic signed [EW-1:0] inv_yz;
    logic signed [EW-1:0] inv_zz;
    logic                 singular;
    logic                 overflow;
  } out_word_t;

endpackage

>>> design/symmetric_matrix_inverse_3x3_core.sv
`timescale 1ns / 1ps
// Symmetric 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// Input channel: a word (six distinct matrix entries) is taken at every rising
// edge where start is high and busy is low. busy is always low: the pipeline
// takes one word every cycle.
// Result channel: out_valid is high for one cycle with the inverse entries,
// singular (zero determinant, entries zero) and overflow (an entry saturated).
// Each word passes the stages of products, cofactors, determinant partial
// products, determinant terms, determinant and magnitudes, then the range
// check and 33 restoring division steps, one step per stage over the six
// lanes at once, then a register for sign fix and saturation.
// Throughput is one word per cycle.
// Synchronous reset clears every valid bit; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`include "symmetric_matrix_inverse_3x3_core_defines.svh"
module symmetric_matrix_inverse_3x3_core #(
  parameter int unsigned FRAC_BITS = smi3_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smi3_pkg::in_word_t  in_word,
  output logic                out_valid,
  output smi3_pkg::out_word_t out_word
);
  import smi3_pkg::*;

  localparam int unsigned LAT = QB + 8;

  // stage 1: products
  logic                 v1_r;
  logic signed [63:0]   p_r [0:11];
  logic signed [EW-1:0] m1_r [0:2];
  // stage 2: cofactors
  logic                 v2_r;
  logic signed [CW-1:0] c2_r [0:NL-1];
  logic signed [EW-1:0] m2_r [0:2];
  // stage 3: determinant partial products
  logic                 v3_r;
  logic signed [CW-1:0] c3_r [0:NL-1];
  logic signed [CW-1:0] lo3_r [0:2];
  logic signed [CW-1:0] hi3_r [0:2];
  // stage 4: determinant terms
  logic                 v4_r;
  logic signed [CW-1:0] c4_r [0:NL-1];
  logic signed [DW-1:0] t4_r [0:2];
  // stage 5: determinant
  logic                 v5_r;
  logic signed [CW-1:0] c5_r [0:NL-1];
  logic signed [DW-1:0] det5_r;
  // stage 6: magnitudes
  logic                 v6_r;
  logic [RW-1:0]        n6_r [0:NL-1];
  logic                 neg6_r [0:NL-1];
  logic [DW-1:0]        den6_r;
  logic                 sing6_r;
  // divider stages, index 0 after the range check
  logic                 dv_r [0:QB];
  logic [RW-1:0]        rem_r [0:QB][0:NL-1];
  logic [QB-1:0]        q_r [0:QB][0:NL-1];
  logic                 big_r [0:QB][0:NL-1];
  logic                 neg_r [0:QB][0:NL-1];
  logic [DW-1:0]        den_r [0:QB];
  logic                 sing_r [0:QB];
  logic [RW-1:0]        rem_nxt [0:QB][0:NL-1];
  logic [QB-1:0]        q_nxt [0:QB][0:NL-1];
  logic                 big_nxt [0:QB][0:NL-1];
  // output
  logic                 out_valid_r;
  out_word_t            out_word_r;
  out_word_t            out_word_nxt;
  logic [EW-1:0]        res [0:NL-1];

  assign busy = 1'b0;

  // datapath ahead of the divider
  always_ff @(posedge clk) begin
    p_r[0]  <= in_word.m_yy * in_word.m_zz;
    p_r[1]  <= in_word.m_yz * in_word.m_yz;
    p_r[2]  <= in_word.m_xz * in_word.m_yz;
    p_r[3]  <= in_word.m_xy * in_word.m_zz;
    p_r[4]  <= in_word.m_xy * in_word.m_yz;
    p_r[5]  <= in_word.m_xz * in_word.m_yy;
    p_r[6]  <= in_word.m_xx * in_word.m_zz;
    p_r[7]  <= in_word.m_xz * in_word.m_xz;
    p_r[8]  <= in_word.m_xy * in_word.m_xz;
    p_r[9]  <= in_word.m_xx * in_word.m_yz;
    p_r[10] <= in_word.m_xx * in_word.m_yy;
    p_r[11] <= in_word.m_xy * in_word.m_xy;
    m1_r[0] <= in_word.m_xx;
    m1_r[1] <= in_word.m_xy;
    m1_r[2] <= in_word.m_xz;
    for (int k = 0; k < NL; k++) begin
      c2_r[k] <= CW'(p_r[2*k]) - CW'(p_r[2*k+1]);
    end
    m2_r <= m1_r;
    c3_r <= c2_r;
    for (int j = 0; j < 3; j++) begin
      lo3_r[j] <= m2_r[j] * $signed({1'b0, c2_r[j][31:0]});
      hi3_r[j] <= m2_r[j] * $signed(c2_r[j][CW-1:32]);
      t4_r[j]  <= DW'($signed({hi3_r[j], 32'd0})) + DW'(lo3_r[j]);
    end
    c4_r   <= c3_r;
    c5_r   <= c4_r;
    det5_r <= t4_r[0] + t4_r[1] + t4_r[2];
    // magnitudes and signs
    den6_r  <= det5_r[DW-1] ? DW'(-det5_r) : DW'(det5_r);
    sing6_r <= (det5_r == '0);
    for (int k = 0; k < NL; k++) begin
      n6_r[k]   <= RW'(c5_r[k][CW-1] ? CW'(-c5_r[k]) : CW'(c5_r[k])) << (2 * FRAC_BITS);
      neg6_r[k] <= c5_r[k][CW-1] ^ det5_r[DW-1];
    end
  end

  // range check and restoring steps, one quotient bit per stage
  always_comb begin
    logic [RW:0] trial;
    trial = '0;
    for (int k = 0; k < NL; k++) begin
      big_nxt[0][k] = (n6_r[k] >= (RW'(den6_r) << QB));
      rem_nxt[0][k] = n6_r[k];
      q_nxt[0][k]   = '0;
    end
    for (int s = 1; s <= QB; s++) begin
      for (int k = 0; k < NL; k++) begin
        trial = {1'b0, rem_r[s-1][k]} - {1'b0, RW'(den_r[s-1]) << (QB - s)};
        big_nxt[s][k] = big_r[s-1][k];
        if (!trial[RW]) begin
          rem_nxt[s][k] = trial[RW-1:0];
          q_nxt[s][k]   = q_r[s-1][k] | (QB'(1) << (QB - s));
        end else begin
          rem_nxt[s][k] = rem_r[s-1][k];
          q_nxt[s][k]   = q_r[s-1][k];
        end
      end
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    for (int s = 0; s <= QB; s++) begin
      rem_r[s] <= rem_nxt[s];
      q_r[s]   <= q_nxt[s];
      big_r[s] <= big_nxt[s];
    end
    neg_r[0]  <= neg6_r;
    den_r[0]  <= den6_r;
    sing_r[0] <= sing6_r;
    for (int s = 1; s <= QB; s++) begin
      neg_r[s]  <= neg_r[s-1];
      den_r[s]  <= den_r[s-1];
      sing_r[s] <= sing_r[s-1];
    end
  end

  // sign fix and saturation
  always_comb begin
    logic ovf;
    ovf = 1'b0;
    for (int k = 0; k < NL; k++) begin
      if (sing_r[QB]) begin
        res[k] = '0;
      end else if (neg_r[QB][k]) begin
        if (big_r[QB][k] || (q_r[QB][k] > QB'(33'h0_8000_0000))) begin
          res[k] = 32'h8000_0000;
          ovf    = 1'b1;
        end else begin
          res[k] = -q_r[QB][k][EW-1:0];
        end
      end else begin
        if (big_r[QB][k] || q_r[QB][k][QB-1] || q_r[QB][k][EW-1]) begin
          res[k] = 32'h7FFF_FFFF;
          ovf    = 1'b1;
        end else begin
          res[k] = q_r[QB][k][EW-1:0];
        end
      end
    end
    out_word_nxt.inv_xx   = res[0];
    out_word_nxt.inv_xy   = res[1];
    out_word_nxt.inv_xz   = res[2];
    out_word_nxt.inv_yy   = res[3];
    out_word_nxt.inv_yz   = res[4];
    out_word_nxt.inv_zz   = res[5];
    out_word_nxt.singular = sing_r[QB];
    out_word_nxt.overflow = ovf;
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s <= QB; s++) begin
        dv_r[s] <= 1'b0;
      end
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      dv_r[0] <= v6_r;
      for (int s = 1; s <= QB; s++) begin
        dv_r[s] <= dv_r[s-1];
      end
      out_valid_r <= dv_r[QB];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `SMI3_ASSERT_NOW(a_sing_zero, out_valid && out_word.singular,
    (!out_word.overflow && out_word.inv_xx == 0 && out_word.inv_xy == 0 &&
     out_word.inv_zz == 0), "singular result not cleared")
  `SMI3_ASSERT_NOW(a_ovf_sat, out_valid && out_word.overflow,
    (!out_word.singular &&
     (out_word.inv_xx == 32'h7FFF_FFFF || out_word.inv_xx == 32'h8000_0000 ||
      out_word.inv_xy == 32'h7FFF_FFFF || out_word.inv_xy == 32'h8000_0000 ||
      out_word.inv_xz == 32'h7FFF_FFFF || out_word.inv_xz == 32'h8000_0000 ||
      out_word.inv_yy == 32'h7FFF_FFFF || out_word.inv_yy == 32'h8000_0000 ||
      out_word.inv_yz == 32'h7FFF_FFFF || out_word.inv_yz == 32'h8000_0000 ||
      out_word.inv_zz == 32'h7FFF_FFFF || out_word.inv_zz == 32'h8000_0000)),
    "overflow without saturated entry")
  `SMI3_ASSERT_NOW(a_latency, start && !busy, ##LAT out_valid, "result missing after fixed latency")
  `SMI3_ASSERT_NEXT(a_stage_chain, dv_r[QB], out_valid, "divider result lost at output")

endmodule
